@@ rtl/core/owbm_pkg.sv @@
// Package for the 1-Wire bus master: command kinds, sequencer phases,
// configuration register indexes and the result record.
// No dependencies; imported by one_wire_bus_master, owbm_checker and the test.
package owbm_pkg;

  typedef enum logic [2:0] {
    KIND_TICK     = 3'd0,
    KIND_RESET    = 3'd1,
    KIND_WR_BIT   = 3'd2,
    KIND_WR_BYTE  = 3'd3,
    KIND_RD_BIT   = 3'd4,
    KIND_RD_BYTE  = 3'd5,
    KIND_RSVD6    = 3'd6,
    KIND_RSVD7    = 3'd7
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_REC  = 4'd3,
    PH_SLOT_LOW = 4'd4,
    PH_SAMPLE   = 4'd5,
    PH_REST     = 4'd6,
    PH_GAP      = 4'd7
  } phase_t;

  localparam int unsigned CFG_NUM   = 7;
  localparam int unsigned CFG_WIDTH = 16;
  localparam int unsigned IDX_WIDTH = 3;

  localparam logic [IDX_WIDTH-1:0] REG_RESET_LOW    = 3'd0;
  localparam logic [IDX_WIDTH-1:0] REG_PRES_WAIT    = 3'd1;
  localparam logic [IDX_WIDTH-1:0] REG_RESET_REC    = 3'd2;
  localparam logic [IDX_WIDTH-1:0] REG_SHORT_LOW    = 3'd3;
  localparam logic [IDX_WIDTH-1:0] REG_READ_SAMPLE  = 3'd4;
  localparam logic [IDX_WIDTH-1:0] REG_SLOT_REST    = 3'd5;
  localparam logic [IDX_WIDTH-1:0] REG_RECOVERY     = 3'd6;

  localparam logic [CFG_WIDTH-1:0] CFG_RESET [CFG_NUM] = '{
    16'd496, 16'd65, 16'd424, 16'd2, 16'd15, 16'd105, 16'd2
  };

  // Result record, drive_low in the lowest bit.
  typedef struct packed {
    logic       command_rejected;
    logic [7:0] read_data;
    logic       presence;
    logic       done;
    logic       busy;
    logic       drive_low;
  } result_t;

  localparam int unsigned RES_WIDTH   = $bits(result_t);
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned IN_TUSER_W  = 3;

endpackage

@@ rtl/core/one_wire_bus_master.sv @@
// Tick-driven 1-Wire bus master: reset/presence, bit and byte read/write.
// Depends on owbm_pkg for kinds, phases, register indexes and result_t.
//
//  channel   | signals                         | carries
//  ----------+---------------------------------+-----------------------------------
//  s_axis    | tvalid tready tdata tuser       | one bus tick: level, command, byte
//  m_axis    | tvalid tready tdata             | one result per tick
//  cfg       | valid ready index data          | timing register writes
//
// Every request is one tick; its result is registered into the output
// stage. The sequencer state is updated only on an accepted request.
// Output is a two-entry stage: requests keep flowing until both entries
// are full. cfg_ready is always high. Reset returns all counts to defaults.
module one_wire_bus_master #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] data_byte, [8] bus_level, [15:9] zero
  input  logic [owbm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] kind
  input  logic [owbm_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [3] presence,
  // [11:4] read_data, [12] command_rejected, [15:13] zero
  output logic [owbm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [owbm_pkg::IDX_WIDTH-1:0]   cfg_index,
  input  logic [owbm_pkg::CFG_WIDTH-1:0]   cfg_data
);
  import owbm_pkg::*;

  localparam int unsigned CW = (COUNT_BITS > CFG_WIDTH) ? COUNT_BITS : CFG_WIDTH;
  localparam logic [CW-1:0] CNT_MAX = CW'({COUNT_BITS{1'b1}});

  logic [CFG_WIDTH-1:0]  cfg_reg [CFG_NUM];

  phase_t                phase, phase_next;
  logic [COUNT_BITS-1:0] tick_count, tick_count_next, cnt_dec;
  logic [2:0]            bit_index, bit_index_next;
  logic [7:0]            shift_data, shift_data_next;
  kind_t                 active_command, active_command_next;
  logic                  presence_flag, presence_flag_next;
  logic [7:0]            last_read, last_read_next;

  kind_t                 kind;
  logic [7:0]            data_byte;
  logic                  bus_level;
  logic                  cmd, is_read, is_byte, is_read_next;
  result_t               res;

  logic                  push, pop;
  logic                  skid_valid;
  result_t               out_res, skid_res;

  // Clamp a register value to a legal phase count: zero counts as one tick.
  function automatic logic [COUNT_BITS-1:0] load_count(input logic [CFG_WIDTH-1:0] v);
    logic [CW-1:0] ext;
    ext = CW'(v);
    if (ext == '0) ext = CW'(1);
    if (ext > CNT_MAX) ext = CNT_MAX;
    return ext[COUNT_BITS-1:0];
  endfunction

  assign kind      = kind_t'(s_axis_tuser[2:0]);
  assign data_byte = s_axis_tdata[7:0];
  assign bus_level = s_axis_tdata[8];

  assign push = s_axis_tvalid && s_axis_tready;
  assign pop  = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = !skid_valid;
  assign cfg_ready = 1'b1;

  assign cmd = (kind == KIND_RESET) || (kind == KIND_WR_BIT) || (kind == KIND_WR_BYTE) ||
               (kind == KIND_RD_BIT) || (kind == KIND_RD_BYTE);
  assign is_read = (active_command == KIND_RD_BIT) || (active_command == KIND_RD_BYTE);
  assign is_byte = (active_command == KIND_WR_BYTE) || (active_command == KIND_RD_BYTE);
  assign is_read_next = (active_command_next == KIND_RD_BIT) ||
                        (active_command_next == KIND_RD_BYTE);
  assign cnt_dec = tick_count - COUNT_BITS'(1);

  always_comb begin
    phase_next          = phase;
    tick_count_next     = tick_count;
    bit_index_next      = bit_index;
    shift_data_next     = shift_data;
    active_command_next = active_command;
    presence_flag_next  = presence_flag;
    last_read_next      = last_read;
    res                 = '0;

    if (phase == PH_IDLE) begin
      if (cmd) begin
        active_command_next = kind;
        bit_index_next      = '0;
        if (kind == KIND_RESET) begin
          phase_next      = PH_RST_LOW;
          tick_count_next = load_count(cfg_reg[REG_RESET_LOW]);
        end else begin
          if (kind == KIND_WR_BIT) shift_data_next = {7'b0, data_byte[0]};
          else if (kind == KIND_WR_BYTE) shift_data_next = data_byte;
          else shift_data_next = '0;
          phase_next      = PH_SLOT_LOW;
          tick_count_next = load_count(cfg_reg[REG_SHORT_LOW]);
        end
      end
    end else begin
      res.command_rejected = cmd;
      tick_count_next = cnt_dec;
      if (cnt_dec == '0) begin
        unique case (phase)
          PH_RST_LOW: begin
            phase_next      = PH_RST_WAIT;
            tick_count_next = load_count(cfg_reg[REG_PRES_WAIT]);
          end
          PH_RST_WAIT: begin
            presence_flag_next = !bus_level;
            phase_next         = PH_RST_REC;
            tick_count_next    = load_count(cfg_reg[REG_RESET_REC]);
          end
          PH_RST_REC: begin
            phase_next = PH_IDLE;
            res.done   = 1'b1;
          end
          PH_SLOT_LOW: begin
            if (is_read) begin
              phase_next      = PH_SAMPLE;
              tick_count_next = load_count(cfg_reg[REG_READ_SAMPLE]);
            end else begin
              phase_next      = PH_REST;
              tick_count_next = load_count(cfg_reg[REG_SLOT_REST]);
            end
          end
          PH_SAMPLE: begin
            shift_data_next[bit_index] = shift_data[bit_index] | bus_level;
            phase_next      = PH_REST;
            tick_count_next = load_count(cfg_reg[REG_SLOT_REST]);
          end
          PH_REST: begin
            if (!is_byte || bit_index == 3'd7) begin
              if (is_read) last_read_next = shift_data;
              phase_next      = PH_IDLE;
              tick_count_next = '0;
              res.done        = 1'b1;
            end else if (cfg_reg[REG_RECOVERY] == '0) begin
              // No recovery gap: the next slot opens right away.
              bit_index_next  = bit_index + 3'd1;
              phase_next      = PH_SLOT_LOW;
              tick_count_next = load_count(cfg_reg[REG_SHORT_LOW]);
            end else begin
              phase_next      = PH_GAP;
              tick_count_next = load_count(cfg_reg[REG_RECOVERY]);
            end
          end
          PH_GAP: begin
            bit_index_next  = bit_index + 3'd1;
            phase_next      = PH_SLOT_LOW;
            tick_count_next = load_count(cfg_reg[REG_SHORT_LOW]);
          end
          default: begin
            phase_next      = PH_IDLE;
            tick_count_next = '0;
          end
        endcase
      end
    end

    if (phase_next == PH_RST_LOW || phase_next == PH_SLOT_LOW) res.drive_low = 1'b1;
    else if (phase_next == PH_REST && !is_read_next)
      res.drive_low = !shift_data_next[bit_index_next];
    res.busy      = (phase_next != PH_IDLE);
    res.presence  = presence_flag_next;
    res.read_data = last_read_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      tick_count     <= '0;
      bit_index      <= '0;
      shift_data     <= '0;
      active_command <= KIND_TICK;
      presence_flag  <= 1'b0;
      last_read      <= '0;
    end else if (push) begin
      phase          <= phase_next;
      tick_count     <= tick_count_next;
      bit_index      <= bit_index_next;
      shift_data     <= shift_data_next;
      active_command <= active_command_next;
      presence_flag  <= presence_flag_next;
      last_read      <= last_read_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CFG_NUM; i++) cfg_reg[i] <= CFG_RESET[i];
    end else if (cfg_valid && cfg_ready && (32'(cfg_index) < CFG_NUM)) begin
      cfg_reg[cfg_index] <= cfg_data;
    end
  end

  // Two-entry output stage: the skid entry holds a result while the
  // output entry waits on the consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!m_axis_tvalid || pop) begin
        m_axis_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_res <= skid_res;
    end else if (push) begin
      if (!m_axis_tvalid || pop) out_res <= res;
      else skid_res <= res;
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'(out_res);

  a_idle_count_zero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (tick_count == '0))
    else $error("idle sequencer holds a nonzero tick count");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    push |-> !(res.done && res.busy))
    else $error("result reports done while still busy");

  a_no_reject_idle: assert property (@(posedge clk) disable iff (rst)
    (push && phase == PH_IDLE) |-> !res.command_rejected)
    else $error("command rejected while idle");

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid entry full while output entry empty");

endmodule

@@ tb/owbm_checker.sv @@
`timescale 1ns / 1ps
// Result checker for one_wire_bus_master: watches the request, result and
// register channels, predicts each tick's result and compares it field by field.
// Depends on owbm_pkg for command kinds, phases, register indexes and result_t.
module owbm_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [owbm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [owbm_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [owbm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [owbm_pkg::IDX_WIDTH-1:0]   cfg_index,
  input  logic [owbm_pkg::CFG_WIDTH-1:0]   cfg_data,
  output int                              mismatches,
  output int                              outstanding,
  output int                              results_checked,
  output logic                            line_busy,
  output logic                            finishing
);
  import owbm_pkg::*;

  localparam int COUNT_BITS   = 16;
  localparam int unsigned COUNT_MAX = (1 << COUNT_BITS) - 1;
  localparam int REPORT_LIMIT = 10;

  logic [CFG_WIDTH-1:0]  timing [CFG_NUM];
  phase_t                seq_phase;
  logic [COUNT_BITS-1:0] ticks_left;
  logic [2:0]            bit_pos;
  logic [7:0]            shift_reg;
  kind_t                 cur_cmd;
  logic                  pres_seen;
  logic [7:0]            last_read;
  result_t               predicted_ticks [$];

  initial begin
    mismatches = 0;
    outstanding = 0;
    results_checked = 0;
  end

  function automatic logic [COUNT_BITS-1:0] phase_len(input logic [CFG_WIDTH-1:0] v);
    int unsigned n;
    // A zero count still lasts one tick, and loads clip at the counter width.
    n = (v == '0) ? 1 : v;
    if (n > COUNT_MAX) n = COUNT_MAX;
    return n[COUNT_BITS-1:0];
  endfunction

  function automatic logic reads_bus(input kind_t c);
    return c == KIND_RD_BIT || c == KIND_RD_BYTE;
  endfunction

  function automatic logic whole_byte(input kind_t c);
    return c == KIND_WR_BYTE || c == KIND_RD_BYTE;
  endfunction

  assign line_busy = seq_phase != PH_IDLE;
  // The next advance ends the running command.
  assign finishing = (ticks_left == 1) &&
                     (seq_phase == PH_RST_REC ||
                      (seq_phase == PH_REST && (!whole_byte(cur_cmd) || bit_pos == 3'd7)));

  task automatic advance_bus(input kind_t k, input logic [7:0] d, input logic lvl,
                             output result_t res);
    logic cmd;
    logic fin;
    logic rej;
    cmd = (k >= KIND_RESET) && (k <= KIND_RD_BYTE);
    fin = 1'b0;
    rej = 1'b0;
    if (seq_phase == PH_IDLE) begin
      if (cmd) begin
        cur_cmd = k;
        bit_pos = '0;
        if (k == KIND_RESET) begin
          seq_phase = PH_RST_LOW;
          ticks_left = phase_len(timing[REG_RESET_LOW]);
        end else begin
          case (k)
            KIND_WR_BIT:  shift_reg = {7'b0, d[0]};
            KIND_WR_BYTE: shift_reg = d;
            default:      shift_reg = '0;
          endcase
          seq_phase = PH_SLOT_LOW;
          ticks_left = phase_len(timing[REG_SHORT_LOW]);
        end
      end
    end else begin
      rej = cmd;
      ticks_left = ticks_left - 1'b1;
      if (ticks_left == '0) begin
        case (seq_phase)
          PH_RST_LOW: begin
            seq_phase = PH_RST_WAIT;
            ticks_left = phase_len(timing[REG_PRES_WAIT]);
          end
          PH_RST_WAIT: begin
            // A slave answers by holding the line low at the sample point.
            pres_seen = ~lvl;
            seq_phase = PH_RST_REC;
            ticks_left = phase_len(timing[REG_RESET_REC]);
          end
          PH_RST_REC: begin
            seq_phase = PH_IDLE;
            fin = 1'b1;
          end
          PH_SLOT_LOW: begin
            if (reads_bus(cur_cmd)) begin
              seq_phase = PH_SAMPLE;
              ticks_left = phase_len(timing[REG_READ_SAMPLE]);
            end else begin
              seq_phase = PH_REST;
              ticks_left = phase_len(timing[REG_SLOT_REST]);
            end
          end
          PH_SAMPLE: begin
            if (lvl) shift_reg[bit_pos] = 1'b1;
            seq_phase = PH_REST;
            ticks_left = phase_len(timing[REG_SLOT_REST]);
          end
          PH_REST: begin
            if (!whole_byte(cur_cmd) || bit_pos == 3'd7) begin
              if (reads_bus(cur_cmd)) last_read = shift_reg;
              seq_phase = PH_IDLE;
              ticks_left = '0;
              fin = 1'b1;
            end else if (timing[REG_RECOVERY] == '0) begin
              // Without a recovery gap the next slot opens at once.
              bit_pos = bit_pos + 1'b1;
              seq_phase = PH_SLOT_LOW;
              ticks_left = phase_len(timing[REG_SHORT_LOW]);
            end else begin
              seq_phase = PH_GAP;
              ticks_left = phase_len(timing[REG_RECOVERY]);
            end
          end
          PH_GAP: begin
            bit_pos = bit_pos + 1'b1;
            seq_phase = PH_SLOT_LOW;
            ticks_left = phase_len(timing[REG_SHORT_LOW]);
          end
          default: begin
            seq_phase = PH_IDLE;
            ticks_left = '0;
          end
        endcase
      end
    end
    res.drive_low = (seq_phase == PH_RST_LOW) || (seq_phase == PH_SLOT_LOW) ||
                    (seq_phase == PH_REST && !reads_bus(cur_cmd) && !shift_reg[bit_pos]);
    res.busy = seq_phase != PH_IDLE;
    res.done = fin;
    res.presence = pres_seen;
    res.read_data = last_read;
    res.command_rejected = rej;
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      for (int r = 0; r < CFG_NUM; r++) timing[r] = CFG_RESET[r];
      seq_phase = PH_IDLE;
      ticks_left = '0;
      bit_pos = '0;
      shift_reg = '0;
      cur_cmd = KIND_TICK;
      pres_seen = 1'b0;
      last_read = '0;
      predicted_ticks.delete();
    end else begin
      // Results first: a result never belongs to a request taken at the same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[RES_WIDTH-1:0]);
        if (predicted_ticks.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("Unexpected result %04h with no request outstanding", m_axis_tdata);
        end else begin
          want = predicted_ticks.pop_front();
          results_checked++;
          if (got !== want || m_axis_tdata[OUT_TDATA_W-1:RES_WIDTH] !== '0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("Result %0d (exp/got): drive_low %0b/%0b busy %0b/%0b done %0b/%0b",
                       results_checked, want.drive_low, got.drive_low, want.busy, got.busy,
                       want.done, got.done);
              $display("  presence %0b/%0b read_data %02h/%02h rejected %0b/%0b pad %0h",
                       want.presence, got.presence, want.read_data, got.read_data,
                       want.command_rejected, got.command_rejected,
                       m_axis_tdata[OUT_TDATA_W-1:RES_WIDTH]);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready && cfg_index < CFG_NUM) timing[cfg_index] = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        advance_bus(kind_t'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[8], want);
        predicted_ticks.push_back(want);
      end
    end
    outstanding = predicted_ticks.size();
  end

endmodule

@@ tb/one_wire_bus_master_test.sv @@
`timescale 1ns / 1ps
// Testbench top for one_wire_bus_master: clock, reset, tick requests, timing
// register writes, result-side stalls and the final verdict.
// Depends on owbm_pkg, one_wire_bus_master and owbm_checker.
module one_wire_bus_master_test;
  import owbm_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_ROUNDS = 5;
  localparam int ROUND_ITEMS   = 70;
  localparam logic [IDX_WIDTH-1:0] REG_NONE  = 3'd7;

  typedef enum int {LVL_LOW, LVL_HIGH, LVL_RANDOM} level_mode_t;
  typedef enum int {POKE_NONE, POKE_EARLY, POKE_LAST} poke_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [7:0] data_byte, [8] bus_level, [15:9] zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // [2:0] kind
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [0] drive_low, [1] busy_res, [2] done_res, [3] presence,
  // [11:4] read_data, [12] command_rejected, [15:13] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [IDX_WIDTH-1:0]   cfg_index = '0;
  logic [CFG_WIDTH-1:0]   cfg_data = '0;

  int   mismatches;
  int   outstanding;
  int   results_checked;
  logic line_busy;
  logic finishing;

  logic [CFG_WIDTH-1:0] next_timing [CFG_NUM];
  int burst_left = 0;
  int ticks_sent = 0;
  int commands_sent = 0;
  int settings_used = 0;
  int cycles = 0;
  int stall_clock = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;

  one_wire_bus_master u_dut (.*);
  owbm_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: rotating stall patterns, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    stall_clock++;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case ((stall_clock / 300) % 3)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ((stall_clock % 7) < 4);
      endcase
    end
  end

  function automatic logic pick_level(input level_mode_t lm);
    if (lm == LVL_LOW) return 1'b0;
    if (lm == LVL_HIGH) return 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [CFG_WIDTH-1:0] pick_ticks();
    case ($urandom_range(0, 5))
      0:       return '0;
      1, 2, 3: return CFG_WIDTH'($urandom_range(1, 4));
      default: return CFG_WIDTH'($urandom_range(5, 12));
    endcase
  endfunction

  // Offers one tick request; called and returns at a falling edge.
  task automatic send_item(input kind_t k, input logic [7:0] d, input logic lvl);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= k;
    s_axis_tdata <= {7'b0, lvl, d};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    ticks_sent++;
    if (k >= KIND_RESET && k <= KIND_RD_BYTE) commands_sent++;
  endtask

  // Issues a command from idle and ticks until it completes, optionally
  // throwing in a second command right after the start or on the last tick.
  task automatic run_cmd(input kind_t k, input logic [7:0] d, input level_mode_t lm,
                         input poke_t pk);
    bit poked;
    poked = 1'b0;
    send_item(k, d, pick_level(lm));
    while (line_busy) begin
      if (!poked && (pk == POKE_EARLY || (pk == POKE_LAST && finishing))) begin
        poked = 1'b1;
        send_item(kind_t'($urandom_range(1, 5)), 8'($urandom_range(0, 255)),
                  pick_level(lm));
      end else begin
        send_item(KIND_TICK, 8'($urandom_range(0, 255)), pick_level(lm));
      end
    end
  endtask

  // Runs the sequencer back to idle and waits for every result.
  task automatic settle();
    while (line_busy)
      send_item(KIND_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes every timing register, then one index past the end that must be ignored.
  task automatic program_timing();
    int r;
    for (r = 0; r < CFG_NUM; r++) write_reg(r[IDX_WIDTH-1:0], next_timing[r]);
    write_reg(REG_NONE, 16'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int   round;
    int   i;
    kind_t k;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Power-up timing: one write slot and one read slot at the default counts.
    run_cmd(KIND_WR_BIT, 8'h01, LVL_RANDOM, POKE_NONE);
    run_cmd(KIND_RD_BIT, 8'h00, LVL_HIGH, POKE_NONE);
    settle();

    // Every count zero: one-tick phases and no gap between slots.
    for (i = 0; i < CFG_NUM; i++) next_timing[i] = '0;
    program_timing();
    run_cmd(KIND_RESET, 8'h00, LVL_HIGH, POKE_NONE);
    run_cmd(KIND_WR_BIT, 8'hFE, LVL_RANDOM, POKE_EARLY);
    run_cmd(KIND_WR_BIT, 8'h01, LVL_RANDOM, POKE_LAST);
    run_cmd(KIND_WR_BYTE, 8'h00, LVL_RANDOM, POKE_NONE);
    run_cmd(KIND_WR_BYTE, 8'hFF, LVL_RANDOM, POKE_NONE);
    run_cmd(KIND_WR_BYTE, 8'hA5, LVL_RANDOM, POKE_LAST);
    run_cmd(KIND_RD_BIT, 8'hFF, LVL_LOW, POKE_NONE);
    run_cmd(KIND_RD_BIT, 8'h00, LVL_HIGH, POKE_LAST);
    run_cmd(KIND_RD_BYTE, 8'h00, LVL_HIGH, POKE_EARLY);
    run_cmd(KIND_RD_BYTE, 8'hFF, LVL_LOW, POKE_NONE);
    run_cmd(KIND_RD_BYTE, 8'h5A, LVL_RANDOM, POKE_NONE);
    run_cmd(KIND_RSVD6, 8'hFF, LVL_HIGH, POKE_NONE);
    run_cmd(KIND_RSVD7, 8'h00, LVL_LOW, POKE_NONE);
    run_cmd(KIND_TICK, 8'hFF, LVL_HIGH, POKE_NONE);
    run_cmd(KIND_RESET, 8'h00, LVL_LOW, POKE_LAST);
    settle();

    // Random traffic over a few short timing settings.
    for (round = 0; round < RANDOM_ROUNDS; round++) begin
      for (i = 0; i < CFG_NUM; i++) next_timing[i] = pick_ticks();
      if (round == 1) next_timing[REG_RECOVERY] = '0;
      program_timing();
      // Results back up during this round while requests keep coming.
      if (round == 2) hold_req = 1'b1;
      for (i = 0; i < ROUND_ITEMS; i++) begin
        if (!line_busy)
          k = ($urandom_range(0, 3) != 0) ? kind_t'($urandom_range(1, 5))
                                          : kind_t'($urandom_range(0, 7));
        else if (finishing && $urandom_range(0, 1) == 1)
          k = kind_t'($urandom_range(1, 5));
        else if ($urandom_range(0, 15) == 0)
          k = kind_t'($urandom_range(1, 5));
        else
          k = ($urandom_range(0, 7) == 0) ? kind_t'($urandom_range(6, 7)) : KIND_TICK;
        send_item(k, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      settle();
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d bus ticks carrying %0d commands over %0d timing settings,",
             ticks_sent, commands_sent, settings_used);
    $display("checked %0d results: %0d mismatches, %0d results missing.",
             results_checked, mismatches, outstanding);
    if (mismatches == 0 && outstanding == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ one_wire_bus_master.f @@
rtl/core/owbm_pkg.sv
rtl/core/one_wire_bus_master.sv
tb/owbm_checker.sv
tb/one_wire_bus_master_test.sv
